[rtl/core/hvd_pkg.sv]
// hvd_pkg: shared constants, types and the arctangent table for the
// haversine distance pipeline. No dependencies.
`default_nettype none
package hvd_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int QBITS       = 30;
  localparam int ANG_W       = 34;      // signed angle / CORDIC datapath
  localparam int MAG_W       = 31;      // coordinate magnitude after wrap
  localparam int RADP_W      = 63;      // magnitude x RAD_K
  localparam int ANGU_W      = 31;      // final central angle, unsigned
  localparam int DIST_W      = 25;
  localparam int NLANE       = 4;

  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_HLAT = 2;
  localparam int LANE_TLAT = 3;

  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    ang_t x;
    ang_t y;
    ang_t z;
  } cordic_t;

  localparam logic [31:0] RAD_K     = 32'd4024455254;
  localparam logic [31:0] HALF_PI_Q = 32'd1686629713;
  localparam logic [31:0] PI_Q      = 32'd3373259426;
  localparam ang_t CORDIC_GAIN_Q    = 34'sd652032874;
  localparam ang_t UNITS_TURN       = 34'sd3600000000;
  localparam ang_t UNITS_HALF_TURN  = 34'sd1800000000;
  localparam logic [QBITS:0] ONE_Q  = {1'b1, {QBITS{1'b0}}};
  localparam logic [23:0] DIAMETER_M = 24'd12742000;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd20016000;

  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_STEPS   = 32;

  localparam int FRONT_STAGES = 7;
  localparam int ROT_STAGES   = CORDIC_STEPS + 1;
  localparam int MIX_STAGES   = 8;
  localparam int BACK_STAGES  = 3;
  localparam int LATENCY = FRONT_STAGES + ROT_STAGES + MIX_STAGES + ROOT_STEPS
                           + CORDIC_STEPS + BACK_STAGES;

  // atan(2^-i) in Q30, truncated
  function automatic ang_t atan_q(input int i);
    ang_t r;
    case (i)
      0:  r = 34'sh03243F6A8;
      1:  r = 34'sh01DAC6705;
      2:  r = 34'sh00FADBAFC;
      3:  r = 34'sh007F56EA6;
      4:  r = 34'sh003FEAB76;
      5:  r = 34'sh001FFD55B;
      6:  r = 34'sh000FFFAAA;
      7:  r = 34'sh0007FFF55;
      8:  r = 34'sh0003FFFEA;
      9:  r = 34'sh0001FFFFD;
      10: r = 34'sh0000FFFFF;
      11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF;
      13: r = 34'sh00001FFFF;
      14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF;
      16: r = 34'sh000003FFF;
      17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF;
      19: r = 34'sh0000007FF;
      20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF;
      22: r = 34'sh0000000FF;
      23: r = 34'sh00000007F;
      24: r = 34'sh00000003F;
      25: r = 34'sh00000001F;
      26: r = 34'sh00000000F;
      27: r = 34'sh000000008;
      28: r = 34'sh000000004;
      29: r = 34'sh000000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/hvd_front.sv]
// hvd_front: coordinate differences, half-turn wrap, conversion to Q30
// radians and quadrant fold. Depends on hvd_pkg.
`default_nettype none
module hvd_front #(
  parameter int COORD_WIDTH = hvd_pkg::COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] here_lon,
  input  logic signed [COORD_WIDTH-2:0] here_lat,
  input  logic signed [COORD_WIDTH-1:0] target_lon,
  input  logic signed [COORD_WIDTH-2:0] target_lat,
  output logic                          out_valid,
  output hvd_pkg::ang_t                 angle [hvd_pkg::NLANE],
  output logic                          flip  [hvd_pkg::NLANE]
);

  logic v1, v2, v3, v4, v5, v6;
  hvd_pkg::ang_t dif1 [hvd_pkg::NLANE];
  hvd_pkg::ang_t wrp2 [hvd_pkg::NLANE];
  logic [hvd_pkg::MAG_W-1:0]  mag3 [hvd_pkg::NLANE];
  logic [hvd_pkg::RADP_W-1:0] prd4 [hvd_pkg::NLANE];
  logic [31:0] rad5 [hvd_pkg::NLANE];
  logic [31:0] fld6 [hvd_pkg::NLANE];
  logic neg3 [hvd_pkg::NLANE];
  logic neg4 [hvd_pkg::NLANE];
  logic neg5 [hvd_pkg::NLANE];
  logic neg6 [hvd_pkg::NLANE];
  logic flp6 [hvd_pkg::NLANE];

  hvd_pkg::ang_t wrp2_next [hvd_pkg::NLANE];
  logic [31:0]   rad5_next [hvd_pkg::NLANE];
  logic [hvd_pkg::RADP_W:0] rsum;
  int sh;

  always_comb begin
    rsum = '0;
    sh   = 32;
    for (int k = 0; k < hvd_pkg::NLANE; k++) begin
      // only the two differences need the wrap
      if (k < hvd_pkg::LANE_HLAT && dif1[k] >= hvd_pkg::UNITS_HALF_TURN) begin
        wrp2_next[k] = dif1[k] - hvd_pkg::UNITS_TURN;
      end else if (k < hvd_pkg::LANE_HLAT && dif1[k] < -hvd_pkg::UNITS_HALF_TURN) begin
        wrp2_next[k] = dif1[k] + hvd_pkg::UNITS_TURN;
      end else begin
        wrp2_next[k] = dif1[k];
      end
      // half angles shift by 32, latitudes by 31; round half up
      sh = (k < hvd_pkg::LANE_HLAT) ? 32 : 31;
      rsum = {1'b0, prd4[k]} + ((hvd_pkg::RADP_W+1)'(1) << (sh - 1));
      rad5_next[k] = 32'(rsum >> sh);
    end
  end

  always_ff @(posedge clk) begin
    dif1[hvd_pkg::LANE_DLAT] <= hvd_pkg::ang_t'(target_lat) - hvd_pkg::ang_t'(here_lat);
    dif1[hvd_pkg::LANE_DLON] <= hvd_pkg::ang_t'(target_lon) - hvd_pkg::ang_t'(here_lon);
    dif1[hvd_pkg::LANE_HLAT] <= hvd_pkg::ang_t'(here_lat);
    dif1[hvd_pkg::LANE_TLAT] <= hvd_pkg::ang_t'(target_lat);
    for (int k = 0; k < hvd_pkg::NLANE; k++) begin
      wrp2[k] <= wrp2_next[k];
      neg3[k] <= wrp2[k][hvd_pkg::ANG_W-1];
      mag3[k] <= hvd_pkg::MAG_W'(wrp2[k][hvd_pkg::ANG_W-1] ? -wrp2[k] : wrp2[k]);
      neg4[k] <= neg3[k];
      prd4[k] <= hvd_pkg::RADP_W'(mag3[k]) * hvd_pkg::RADP_W'(hvd_pkg::RAD_K);
      neg5[k] <= neg4[k];
      rad5[k] <= rad5_next[k];
      neg6[k] <= neg5[k];
      if (rad5[k] > hvd_pkg::HALF_PI_Q) begin
        fld6[k] <= hvd_pkg::PI_Q - rad5[k];
        flp6[k] <= 1'b1;
      end else begin
        fld6[k] <= rad5[k];
        flp6[k] <= 1'b0;
      end
      angle[k] <= neg6[k] ? -hvd_pkg::ang_t'(fld6[k]) : hvd_pkg::ang_t'(fld6[k]);
      flip[k]  <= flp6[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; out_valid <= v6;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hvd_cordic_rot.sv]
// hvd_cordic_rot: rotation-mode CORDIC, one step per register stage,
// giving sine and (reflected) cosine. Depends on hvd_pkg.
`default_nettype none
module hvd_cordic_rot (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  hvd_pkg::ang_t angle,
  input  logic          flip,
  output logic          out_valid,
  output hvd_pkg::ang_t sin_q,
  output hvd_pkg::ang_t cos_q
);

  localparam int S = hvd_pkg::CORDIC_STEPS;

  hvd_pkg::cordic_t st  [1:S];
  logic             flp [1:S];
  logic             vld [1:S];
  hvd_pkg::cordic_t init;

  function automatic hvd_pkg::cordic_t rot_step(input hvd_pkg::cordic_t c, input int i);
    hvd_pkg::cordic_t r;
    if (!c.z[hvd_pkg::ANG_W-1]) begin
      r.x = c.x - (c.y >>> i);
      r.y = c.y + (c.x >>> i);
      r.z = c.z - hvd_pkg::atan_q(i);
    end else begin
      r.x = c.x + (c.y >>> i);
      r.y = c.y - (c.x >>> i);
      r.z = c.z + hvd_pkg::atan_q(i);
    end
    return r;
  endfunction

  always_comb begin
    init.x = hvd_pkg::CORDIC_GAIN_Q;
    init.y = '0;
    init.z = angle;
  end

  always_ff @(posedge clk) begin
    st[1]  <= rot_step(init, 0);
    flp[1] <= flip;
    for (int i = 1; i < S; i++) begin
      st[i+1]  <= rot_step(st[i], i);
      flp[i+1] <= flp[i];
    end
    sin_q <= st[S].y;
    cos_q <= flp[S] ? -st[S].x : st[S].x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= S; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld[1] <= in_valid;
      for (int i = 1; i < S; i++) vld[i+1] <= vld[i];
      out_valid <= vld[S];
    end
  end

endmodule
`default_nettype wire

[rtl/core/hvd_mix.sv]
// hvd_mix: haversine term a = sin^2 + cos*cos*sin^2 with Q30 rounding,
// clamped to [0, 1], plus 1 - a. Depends on hvd_pkg.
`default_nettype none
module hvd_mix (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  hvd_pkg::ang_t        s_lat,
  input  hvd_pkg::ang_t        s_lon,
  input  hvd_pkg::ang_t        c_here,
  input  hvd_pkg::ang_t        c_tgt,
  output logic                 out_valid,
  output logic [hvd_pkg::QBITS:0] a_q,
  output logic [hvd_pkg::QBITS:0] b_q
);

  localparam int QB = hvd_pkg::QBITS;

  logic [7:1] vld;
  logic [31:0] ml1, mn1, mh1, mt1;
  logic        ngc1, ngc2, ngc3, ngc4, ngc5;
  logic [63:0] sl2, sn2, cc2, t4;
  logic [31:0] sl3, sn3, cc3, sl4, sl5, tq5;
  logic signed [34:0] sum6;
  logic [QB:0] a7;

  function automatic logic [31:0] mag32(input hvd_pkg::ang_t v);
    return 32'(v[hvd_pkg::ANG_W-1] ? -v : v);
  endfunction

  function automatic logic [31:0] qround(input logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, p} + (65'd1 << (QB - 1));
    return 32'(s >> QB);
  endfunction

  always_ff @(posedge clk) begin
    ml1  <= mag32(s_lat);
    mn1  <= mag32(s_lon);
    mh1  <= mag32(c_here);
    mt1  <= mag32(c_tgt);
    ngc1 <= c_here[hvd_pkg::ANG_W-1] ^ c_tgt[hvd_pkg::ANG_W-1];
    sl2  <= 64'(ml1) * 64'(ml1);
    sn2  <= 64'(mn1) * 64'(mn1);
    cc2  <= 64'(mh1) * 64'(mt1);
    ngc2 <= ngc1;
    sl3  <= qround(sl2);
    sn3  <= qround(sn2);
    cc3  <= qround(cc2);
    ngc3 <= ngc2;
    t4   <= 64'(cc3) * 64'(sn3);
    sl4  <= sl3;
    ngc4 <= ngc3;
    tq5  <= qround(t4);
    sl5  <= sl4;
    ngc5 <= ngc4;
    sum6 <= ngc5 ? $signed({3'b000, sl5}) - $signed({3'b000, tq5})
                 : $signed({3'b000, sl5}) + $signed({3'b000, tq5});
    if (sum6[34]) begin
      a7 <= '0;
    end else if (sum6 > $signed(35'(hvd_pkg::ONE_Q))) begin
      a7 <= hvd_pkg::ONE_Q;
    end else begin
      a7 <= sum6[QB:0];
    end
    a_q <= a7;
    b_q <= hvd_pkg::ONE_Q - a7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[6:1], in_valid};
      out_valid <= vld[7];
    end
  end

endmodule
`default_nettype wire

[rtl/core/hvd_isqrt.sv]
// hvd_isqrt: bitwise integer square root of (v << 30), one result bit per
// register stage, rounding down. Depends on hvd_pkg.
`default_nettype none
module hvd_isqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [hvd_pkg::QBITS:0] val,
  output logic                    out_valid,
  output logic [31:0]             root
);

  localparam int S = hvd_pkg::ROOT_STEPS;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } root_t;

  root_t st  [1:S];
  logic  vld [1:S];
  root_t init;

  function automatic root_t root_step(input root_t c, input int i);
    root_t       r;
    logic [63:0] bitv;
    logic [63:0] trial;
    bitv  = 64'd1 << (62 - 2 * i);
    trial = c.res + bitv;
    if (c.rem >= trial) begin
      r.rem = c.rem - trial;
      r.res = (c.res >> 1) + bitv;
    end else begin
      r.rem = c.rem;
      r.res = c.res >> 1;
    end
    return r;
  endfunction

  always_comb begin
    init.rem = 64'(val) << hvd_pkg::QBITS;
    init.res = '0;
  end

  always_ff @(posedge clk) begin
    st[1] <= root_step(init, 0);
    for (int i = 1; i < S; i++) st[i+1] <= root_step(st[i], i);
  end

  assign root = st[S].res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= S; i++) vld[i] <= 1'b0;
    end else begin
      vld[1] <= in_valid;
      for (int i = 1; i < S; i++) vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[S];

endmodule
`default_nettype wire

[rtl/core/hvd_cordic_vec.sv]
// hvd_cordic_vec: vectoring-mode CORDIC giving atan2(y, x) in Q30, one step
// per register stage. Depends on hvd_pkg.
`default_nettype none
module hvd_cordic_vec (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   x_in,
  input  logic [31:0]   y_in,
  output logic          out_valid,
  output hvd_pkg::ang_t angle
);

  localparam int S = hvd_pkg::CORDIC_STEPS;

  hvd_pkg::cordic_t st  [1:S];
  logic             vld [1:S];
  hvd_pkg::cordic_t init;

  function automatic hvd_pkg::cordic_t vec_step(input hvd_pkg::cordic_t c, input int i);
    hvd_pkg::cordic_t r;
    if (!c.y[hvd_pkg::ANG_W-1] && c.y != '0) begin
      r.x = c.x + (c.y >>> i);
      r.y = c.y - (c.x >>> i);
      r.z = c.z + hvd_pkg::atan_q(i);
    end else begin
      r.x = c.x - (c.y >>> i);
      r.y = c.y + (c.x >>> i);
      r.z = c.z - hvd_pkg::atan_q(i);
    end
    return r;
  endfunction

  always_comb begin
    init.x = hvd_pkg::ang_t'(x_in);
    init.y = hvd_pkg::ang_t'(y_in);
    init.z = '0;
  end

  always_ff @(posedge clk) begin
    st[1] <= vec_step(init, 0);
    for (int i = 1; i < S; i++) st[i+1] <= vec_step(st[i], i);
  end

  assign angle = st[S].z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= S; i++) vld[i] <= 1'b0;
    end else begin
      vld[1] <= in_valid;
      for (int i = 1; i < S; i++) vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[S];

endmodule
`default_nettype wire

[rtl/core/haversine_distance.sv]
// haversine_distance: top level, great-circle distance by the haversine
// formula. Depends on hvd_pkg and the hvd_* pipeline modules.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  input    | start / busy     | here_lon, here_lat, target_lon, target_lat
//  result   | done (strobe)    | distance_m
//
// One item may be taken every cycle; busy stays low as nothing stalls.
// The pipeline depth is set mostly by the two 30-step CORDIC chains and the
// 32-step root chain, each one step per register stage.
// done lasts one cycle per item and cannot be held off by the receiver.
// Synchronous reset clears the valid bits only; items in flight are dropped.
`default_nettype none
module haversine_distance #(
  parameter int COORD_WIDTH = hvd_pkg::COORD_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] here_lon,
  input  logic signed [COORD_WIDTH-2:0] here_lat,
  input  logic signed [COORD_WIDTH-1:0] target_lon,
  input  logic signed [COORD_WIDTH-2:0] target_lat,
  output logic                          done,
  output logic [hvd_pkg::DIST_W-1:0]    distance_m
);

  // front end: four angle lanes
  logic          fr_valid;
  hvd_pkg::ang_t fr_angle [hvd_pkg::NLANE];
  logic          fr_flip  [hvd_pkg::NLANE];

  // trig outputs
  logic          rot_valid [hvd_pkg::NLANE];
  hvd_pkg::ang_t s_lat, s_lon, c_here, c_tgt;

  // haversine term
  logic                    mx_valid;
  logic [hvd_pkg::QBITS:0] a_q, b_q;

  // roots and central angle
  logic          ry_valid, rx_valid, vec_valid;
  logic [31:0]   ry, rx;
  hvd_pkg::ang_t ang;

  // back end
  logic                         v1, v2;
  logic [hvd_pkg::ANGU_W-1:0]   angu;
  logic [hvd_pkg::ANGU_W+23:0]  prod;
  logic [hvd_pkg::ANGU_W+24:0]  rnd;
  logic [hvd_pkg::DIST_W:0]     dq;

  assign busy = 1'b0;   // fully pipelined, never refuses an item

  hvd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .here_lon   (here_lon),
    .here_lat   (here_lat),
    .target_lon (target_lon),
    .target_lat (target_lat),
    .out_valid  (fr_valid),
    .angle      (fr_angle),
    .flip       (fr_flip)
  );

  // sine lanes ignore the cosine reflection
  hvd_cordic_rot u_rot_dlat (
    .clk(clk), .rst(rst), .in_valid(fr_valid),
    .angle(fr_angle[hvd_pkg::LANE_DLAT]), .flip(1'b0),
    .out_valid(rot_valid[hvd_pkg::LANE_DLAT]), .sin_q(s_lat), .cos_q()
  );
  hvd_cordic_rot u_rot_dlon (
    .clk(clk), .rst(rst), .in_valid(fr_valid),
    .angle(fr_angle[hvd_pkg::LANE_DLON]), .flip(1'b0),
    .out_valid(rot_valid[hvd_pkg::LANE_DLON]), .sin_q(s_lon), .cos_q()
  );
  hvd_cordic_rot u_rot_hlat (
    .clk(clk), .rst(rst), .in_valid(fr_valid),
    .angle(fr_angle[hvd_pkg::LANE_HLAT]), .flip(fr_flip[hvd_pkg::LANE_HLAT]),
    .out_valid(rot_valid[hvd_pkg::LANE_HLAT]), .sin_q(), .cos_q(c_here)
  );
  hvd_cordic_rot u_rot_tlat (
    .clk(clk), .rst(rst), .in_valid(fr_valid),
    .angle(fr_angle[hvd_pkg::LANE_TLAT]), .flip(fr_flip[hvd_pkg::LANE_TLAT]),
    .out_valid(rot_valid[hvd_pkg::LANE_TLAT]), .sin_q(), .cos_q(c_tgt)
  );

  hvd_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid[hvd_pkg::LANE_DLAT] && rot_valid[hvd_pkg::LANE_DLON] &&
                rot_valid[hvd_pkg::LANE_HLAT] && rot_valid[hvd_pkg::LANE_TLAT]),
    .s_lat     (s_lat),
    .s_lon     (s_lon),
    .c_here    (c_here),
    .c_tgt     (c_tgt),
    .out_valid (mx_valid),
    .a_q       (a_q),
    .b_q       (b_q)
  );

  hvd_isqrt u_sqrt_a (
    .clk(clk), .rst(rst), .in_valid(mx_valid), .val(a_q),
    .out_valid(ry_valid), .root(ry)
  );
  hvd_isqrt u_sqrt_b (
    .clk(clk), .rst(rst), .in_valid(mx_valid), .val(b_q),
    .out_valid(rx_valid), .root(rx)
  );

  hvd_cordic_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ry_valid && rx_valid),
    .x_in      (rx),
    .y_in      (ry),
    .out_valid (vec_valid),
    .angle     (ang)
  );

  // scale: negative angle taken as zero, times diameter, round, saturate
  always_comb begin
    rnd = {1'b0, prod} + ((hvd_pkg::ANGU_W+25)'(1) << (hvd_pkg::QBITS - 1));
    dq  = rnd[hvd_pkg::ANGU_W+24:hvd_pkg::QBITS];
  end

  always_ff @(posedge clk) begin
    angu <= ang[hvd_pkg::ANG_W-1] ? '0 : hvd_pkg::ANGU_W'(ang);
    prod <= (hvd_pkg::ANGU_W+24)'(angu) * (hvd_pkg::ANGU_W+24)'(hvd_pkg::DIAMETER_M);
    distance_m <= (dq > (hvd_pkg::DIST_W+1)'(hvd_pkg::DIST_MAX)) ? hvd_pkg::DIST_MAX
                                                             : dq[hvd_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= vec_valid;
      v2   <= v1;
      done <= v2;
    end
  end

endmodule
`default_nettype wire

[rtl/core/hvd_checker.sv]
// hvd_checker: port-level assertions for haversine_distance, bound to the
// top level. Depends on hvd_pkg.
`default_nettype none
module hvd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [hvd_pkg::DIST_W-1:0] distance_m
);

  localparam int LAT = hvd_pkg::LATENCY;

  // every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item did not produce a result");

  // no result without a matching accepted item
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result with no matching item");

  // saturation holds on every delivered item
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (distance_m <= hvd_pkg::DIST_MAX))
    else $error("distance above saturation limit");

  // pipeline never pushes back
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);
`default_nettype wire

[bench/haversine_distance_tb.sv]
// haversine_distance_tb: self-checking bench for the haversine distance
// pipeline; a fixed-point predictor computes each distance item by item.
// Depends on hvd_pkg and the haversine_distance RTL.
`default_nettype none
module haversine_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = hvd_pkg::COORD_W_DEF;

  // predictor and stimulus constants
  localparam longint TURN_UNITS      = 64'sd3600000000;
  localparam longint HALF_TURN_UNITS = 64'sd1800000000;
  localparam longint RADK            = 64'd4024455254;
  localparam longint HALF_PI_L       = 64'sd1686629713;
  localparam longint PI_L            = 64'sd3373259426;
  localparam longint GAIN_L          = 64'sd652032874;
  localparam longint ONE_L           = 64'sd1 << hvd_pkg::QBITS;
  localparam longint DIAM_L          = 64'd12742000;
  localparam longint DMAX_L          = 64'd20016000;
  localparam int     N_RANDOM        = 1050;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic signed [CW-1:0]       here_lon = '0;
  logic signed [CW-2:0]       here_lat = '0;
  logic signed [CW-1:0]       target_lon = '0;
  logic signed [CW-2:0]       target_lat = '0;
  logic                       done;
  logic [hvd_pkg::DIST_W-1:0] distance_m;

  haversine_distance #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .here_lon(here_lon), .here_lat(here_lat),
    .target_lon(target_lon), .target_lat(target_lat),
    .done(done), .distance_m(distance_m)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor. Longints stand for the signed datapath; every step mirrors the
  // block's fixed-point rounding so the answer must match to the metre.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic signed [CW-1:0] hlon;
    logic signed [CW-2:0] hlat;
    logic signed [CW-1:0] tlon;
    logic signed [CW-2:0] tlat;
  } coord_item_t;

  // atan(2^-i), Q30, truncated
  function automatic longint arctan_step(input int i);
    longint t [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
    return t[i];
  endfunction

  function automatic longint abs_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Q30 product, rounded half away from zero
  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned p;
    p = (longint'(abs_of(a)) * longint'(abs_of(b)) + (64'd1 << (hvd_pkg::QBITS-1)))
        >> hvd_pkg::QBITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // 1e-7 degree units to Q30 radians; 31 for a latitude, 32 for a half angle
  function automatic longint units_to_rad(input longint u, input int sh);
    longint unsigned p;
    p = (longint'(abs_of(u)) * RADK + (64'd1 << (sh-1))) >> sh;
    return (u < 0) ? -longint'(p) : longint'(p);
  endfunction

  // difference folded into [-180, 180) degrees
  function automatic longint fold_half_turn(input longint d);
    longint r;
    r = d % TURN_UNITS;
    if (r >= HALF_TURN_UNITS) r -= TURN_UNITS;
    else if (r < -HALF_TURN_UNITS) r += TURN_UNITS;
    return r;
  endfunction

  // rotation CORDIC with reflection beyond +-pi/2
  function automatic void rotate_sin_cos(input longint z_in, output longint s,
                                         output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_L; y = 0; z = z_in; flip = 1'b0;
    if (z > HALF_PI_L) begin
      z = PI_L - z; flip = 1'b1;
    end else if (z < -HALF_PI_L) begin
      z = -PI_L - z; flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step(i);
      end
      x = nx;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint root_floor(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in; r = 0; b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // vectoring CORDIC: angle of (x, y)
  function automatic longint vector_angle(input longint x_in, input longint y_in);
    longint x, y, z, nx;
    x = x_in; y = y_in; z = 0;
    for (int i = 0; i < 30; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [hvd_pkg::DIST_W-1:0] great_circle_m(input coord_item_t c);
    longint hlon, hlat, tlon, tlat, s_lat, s_lon, c_h, c_t, dummy, hav, ry, rx, ang;
    longint unsigned d;
    hlon = c.hlon; hlat = c.hlat; tlon = c.tlon; tlat = c.tlat;
    rotate_sin_cos(units_to_rad(fold_half_turn(tlat - hlat), 32), s_lat, dummy);
    rotate_sin_cos(units_to_rad(fold_half_turn(tlon - hlon), 32), s_lon, dummy);
    rotate_sin_cos(units_to_rad(hlat, 31), dummy, c_h);
    rotate_sin_cos(units_to_rad(tlat, 31), dummy, c_t);
    hav = q30_mul(s_lat, s_lat) + q30_mul(q30_mul(c_h, c_t), q30_mul(s_lon, s_lon));
    // rounding may push the haversine term just outside [0, 1]
    if (hav < 0) hav = 0;
    if (hav > ONE_L) hav = ONE_L;
    ry = root_floor(longint'(hav) << hvd_pkg::QBITS);
    rx = root_floor(longint'(ONE_L - hav) << hvd_pkg::QBITS);
    ang = vector_angle(rx, ry);
    if (ang < 0) ang = 0;   // vectoring can end a hair below zero
    d = (longint'(ang) * DIAM_L + (64'd1 << (hvd_pkg::QBITS-1))) >> hvd_pkg::QBITS;
    if (d > DMAX_L) d = DMAX_L;
    return d[hvd_pkg::DIST_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: expected typed in only where obvious, -1 means predict.
  // ---------------------------------------------------------------------------
  typedef struct {
    coord_item_t c;
    longint      want;
  } coord_row_t;

  localparam int N_ROWS = 16;
  coord_row_t rows [N_ROWS];

  initial begin
    // same point, zero distance
    rows[0]  = '{'{32'sd0, 31'sd0, 32'sd0, 31'sd0}, 0};
    rows[1]  = '{'{32'sd123456789, -31'sd456789012, 32'sd123456789,
                   -31'sd456789012}, 0};
    // antipodes and pole to pole
    rows[2]  = '{'{32'sd0, 31'sd0, 32'sd1800000000, 31'sd0}, -1};
    rows[3]  = '{'{32'sd0, 31'sd900000000, 32'sd0, -31'sd900000000}, -1};
    rows[4]  = '{'{-32'sd1800000000, -31'sd900000000, 32'sd1800000000,
                   31'sd900000000}, -1};
    // date line crossing: wrap of the longitude difference
    rows[5]  = '{'{32'sd1799000000, 31'sd100000000, -32'sd1799000000,
                   31'sd100000000}, -1};
    rows[6]  = '{'{-32'sd1800000000, 31'sd0, 32'sd1799999999, 31'sd0}, -1};
    // one unit apart
    rows[7]  = '{'{32'sd0, 31'sd0, 32'sd1, 31'sd0}, -1};
    rows[8]  = '{'{32'sd0, 31'sd0, 32'sd0, 31'sd1}, -1};
    // full-width extremes, latitudes beyond the poles included
    rows[9]  = '{'{32'h7FFFFFFF, 31'h3FFFFFFF, 32'h80000000, 31'h40000000}, -1};
    rows[10] = '{'{32'h80000000, 31'h40000000, 32'h7FFFFFFF, 31'h3FFFFFFF}, -1};
    rows[11] = '{'{32'hFFFFFFFF, 31'h7FFFFFFF, 32'h00000000, 31'h00000000}, -1};
    rows[12] = '{'{32'sd0, 31'sd950000000, 32'sd900000000, -31'sd1000000000}, -1};
    // near-antipodal, rounding may push the term past one
    rows[13] = '{'{32'sd0, 31'sd1, 32'sd1800000000, -31'sd1}, -1};
    rows[14] = '{'{32'sd450000000, 31'sd450000000, -32'sd1350000000,
                   -31'sd450000000}, -1};
    rows[15] = '{'{32'sd900000000, 31'sd0, -32'sd900000000, 31'sd0}, -1};
  end

  // ---------------------------------------------------------------------------
  // Expectation store and result checker
  // ---------------------------------------------------------------------------
  logic [hvd_pkg::DIST_W-1:0] pending_dist [$];
  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_dist.size() == 0) begin
        $error("distance_m: no item outstanding, actual %0d", distance_m);
        errors++;
      end else begin
        if (distance_m !== pending_dist[0]) begin
          $error("distance_m: expected %0d actual %0d", pending_dist[0], distance_m);
          errors++;
        end
        void'(pending_dist.pop_front());
        n_checked++;
      end
    end
  end

  function automatic coord_item_t random_item();
    coord_item_t c;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      // raw noise: every bit of every field
      c.hlon = $urandom; c.hlat = 31'($urandom);
      c.tlon = $urandom; c.tlat = 31'($urandom);
    end else begin
      c.hlon = $signed($urandom_range(0, 3600000000)) - 32'sd1800000000;
      c.hlat = 31'($signed($urandom_range(0, 1800000000)) - 32'sd900000000);
      if (mode < 5) begin
        // nearby waypoint
        c.tlon = c.hlon + $signed($urandom_range(0, 2000000)) - 32'sd1000000;
        c.tlat = 31'(c.hlat + $signed($urandom_range(0, 2000000)) - 32'sd1000000);
      end else begin
        c.tlon = $signed($urandom_range(0, 3600000000)) - 32'sd1800000000;
        c.tlat = 31'($signed($urandom_range(0, 1800000000)) - 32'sd900000000);
      end
    end
    return c;
  endfunction

  // present one item, hold until the block takes it; start drops only for a gap
  task automatic send_item(input coord_item_t c, input logic [hvd_pkg::DIST_W-1:0] want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    here_lon   <= c.hlon;
    here_lat   <= c.hlat;
    target_lon <= c.tlon;
    target_lat <= c.tlat;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_dist.push_back(want);
    n_sent++;
  endtask

  initial begin
    coord_item_t c;
    logic [hvd_pkg::DIST_W-1:0] want;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      want = (rows[r].want >= 0) ? rows[r].want[hvd_pkg::DIST_W-1:0]
                                 : great_circle_m(rows[r].c);
      send_item(rows[r].c, want);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      c = random_item();
      send_item(c, great_circle_m(c));
    end
    start <= 1'b0;

    while (pending_dist.size() != 0) @(posedge clk);
    repeat (hvd_pkg::LATENCY + 10) @(posedge clk);

    $display("Checked %0d distances from %0d items (directed and random).",
             n_checked, n_sent);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // generous watchdog: covers the longest gap before every item, plus pipeline drain
  initial begin
    #(10ns * 200000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
